/* rtl/rmh_pkg.sv */
// shared types and constants for the running median histogram block
`default_nettype none

package rmh_pkg;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_ABSENT = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  median_value;
        logic [15:0] total_count;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_MOVE
    } state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic commit;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic move_needed;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/rmh_ctrl.sv */
// controller state machine sequencing bin update, median move and result load
`default_nettype none

module rmh_ctrl
    import rmh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_free;

    assign out_free = !stat.out_busy || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                priority if (stat.move_needed)
                begin
                    state_next = S_MOVE;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MOVE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_UPDATE:
            begin
                cmd.update   = 1'b1;
                cmd.commit   = stat.move_needed || out_free;
                cmd.load_out = !stat.move_needed && out_free;
            end
            S_MOVE:
            begin
                cmd.finish   = out_free;
                cmd.load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/rmh_datapath.sv */
// histogram memory, occupancy flags, median tracking and result register
`default_nettype none

module rmh_datapath
    import rmh_pkg::*;
#(
    parameter int VALUE_LEVELS = 256,
    parameter int COUNT_BITS   = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    output out_item_t out_data,
    output logic      out_valid,
    input  logic      out_ready,
    input  cmd_t      cmd,
    output stat_t     stat
);

    localparam int                    IW         = $clog2(VALUE_LEVELS);
    localparam logic [IW-1:0]         TOP_BIN    = IW'(VALUE_LEVELS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    function automatic logic [IW-1:0] find_above(
        input logic [VALUE_LEVELS-1:0] f,
        input logic [IW-1:0]           m
    );
        logic          found;
        logic [IW-1:0] pos;
        found = 1'b0;
        pos   = '0;
        for (int i = 0; i < VALUE_LEVELS; i++)
        begin
            if (!found && f[i] && (IW'(i) > m))
            begin
                found = 1'b1;
                pos   = IW'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [IW-1:0] find_below(
        input logic [VALUE_LEVELS-1:0] f,
        input logic [IW-1:0]           m
    );
        logic          found;
        logic [IW-1:0] pos;
        found = 1'b0;
        pos   = '0;
        for (int i = VALUE_LEVELS - 1; i >= 0; i--)
        begin
            if (!found && f[i] && (IW'(i) < m))
            begin
                found = 1'b1;
                pos   = IW'(i);
            end
        end
        return pos;
    endfunction

    logic [COUNT_BITS-1:0]   mem [VALUE_LEVELS];

    logic [VALUE_LEVELS-1:0] flags_reg;
    logic [COUNT_BITS-1:0]   n_reg;
    logic [COUNT_BITS-1:0]   c_reg;
    logic [COUNT_BITS-1:0]   hm_reg;
    logic [IW-1:0]           m_reg;
    logic                    down_reg;
    logic [1:0]              status_reg;
    logic [1:0]              act_reg;
    logic [IW-1:0]           idx_reg;
    logic [COUNT_BITS-1:0]   rd_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic [31:0]             sample_w;
    logic [IW-1:0]           idx_in;
    logic [COUNT_BITS-1:0]   h_cur;
    logic [COUNT_BITS-1:0]   h_new;
    logic [COUNT_BITS-1:0]   n_new;
    logic [COUNT_BITS-1:0]   c_new;
    logic [COUNT_BITS-1:0]   hm_new;
    logic [COUNT_BITS-1:0]   t_new;
    logic [COUNT_BITS:0]     c_hi;
    logic [1:0]              status_new;
    logic                    changed;
    logic                    add_op;
    logic                    move_up;
    logic                    move_down;
    logic [VALUE_LEVELS-1:0] flags_upd;
    logic [VALUE_LEVELS-1:0] flags_view;
    logic [IW-1:0]           up_bin;
    logic [IW-1:0]           below_bin;
    logic [IW-1:0]           rd_addr;
    logic                    rd_en;
    logic                    wr_en;
    logic [COUNT_BITS-1:0]   c_mv;
    logic [COUNT_BITS-1:0]   n_v;
    logic [COUNT_BITS-1:0]   c_v;
    logic [IW:0]             med_sum;
    logic [IW-1:0]           med;
    logic [31:0]             med_w;
    logic [31:0]             n_w;

    // clamp samples above the top level
    assign sample_w = 32'(in_data.sample);
    assign idx_in   = (sample_w >= 32'(VALUE_LEVELS)) ? TOP_BIN : IW'(sample_w);

    // bin update
    always_comb
    begin
        h_cur      = flags_reg[idx_reg] ? rd_reg : '0;
        h_new      = h_cur;
        n_new      = n_reg;
        status_new = STAT_OK;
        changed    = 1'b0;
        add_op     = 1'b0;
        unique case (act_reg)
            ACT_ADD:
            begin
                if (n_reg == COUNT_FULL)
                begin
                    status_new = STAT_FULL;
                end
                else
                begin
                    h_new   = h_cur + 1'b1;
                    n_new   = n_reg + 1'b1;
                    changed = 1'b1;
                    add_op  = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (h_cur == '0)
                begin
                    status_new = STAT_ABSENT;
                end
                else
                begin
                    h_new   = h_cur - 1'b1;
                    n_new   = n_reg - 1'b1;
                    changed = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                n_new = '0;
            end
            default:
            begin
                n_new = n_reg;
            end
        endcase
    end

    // median bin move decision
    always_comb
    begin
        c_new = c_reg;
        if (changed && (idx_reg < m_reg))
        begin
            c_new = add_op ? (c_reg + 1'b1) : (c_reg - 1'b1);
        end
        hm_new = (changed && (idx_reg == m_reg)) ? h_new : hm_reg;
        t_new  = n_new >> 1;
        c_hi   = {1'b0, c_new} + {1'b0, hm_new};

        flags_upd = flags_reg;
        if (changed)
        begin
            flags_upd[idx_reg] = (h_new != '0);
        end
        if (act_reg == ACT_CLEAR)
        begin
            flags_upd = '0;
        end

        move_down = (n_new != '0) && (t_new < c_new);
        move_up   = (n_new != '0) && !move_down && ({1'b0, t_new} >= c_hi);
    end

    assign flags_view = cmd.update ? flags_upd : flags_reg;
    assign up_bin     = find_above(flags_upd, m_reg);
    assign below_bin  = find_below(flags_view, m_reg);

    // reported median
    always_comb
    begin
        c_mv    = down_reg ? (c_reg - rd_reg) : c_reg;
        n_v     = cmd.update ? n_new : n_reg;
        c_v     = cmd.update ? c_new : c_mv;
        med_sum = {1'b0, m_reg} + {1'b0, below_bin};
        priority if (n_v == '0)
        begin
            med = '0;
        end
        else if (!n_v[0] && (c_v == (n_v >> 1)) && (m_reg != '0))
        begin
            med = med_sum[IW:1];
        end
        else
        begin
            med = m_reg;
        end
        med_w = 32'(med);
        n_w   = 32'(n_v);
    end

    assign rd_addr = cmd.accept ? idx_in : (move_up ? up_bin : below_bin);
    assign rd_en   = cmd.accept || (cmd.commit && (move_up || move_down));
    assign wr_en   = cmd.commit && changed;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_reg] <= h_new;
        end
        if (rd_en)
        begin
            if (wr_en && (idx_reg == rd_addr))
            begin
                rd_reg <= h_new;
            end
            else
            begin
                rd_reg <= mem[rd_addr];
            end
        end
        if (cmd.accept)
        begin
            act_reg <= in_data.action;
            idx_reg <= idx_in;
        end
        if (cmd.commit)
        begin
            status_reg <= status_new;
        end
        if (cmd.load_out)
        begin
            out_data_reg.median_value <= med_w[7:0];
            out_data_reg.total_count  <= n_w[15:0];
            out_data_reg.status       <= cmd.update ? status_new : status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            n_reg         <= '0;
            c_reg         <= '0;
            hm_reg        <= '0;
            m_reg         <= '0;
            down_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                flags_reg <= flags_upd;
                n_reg     <= n_new;
                down_reg  <= move_down;
                priority if (n_new == '0)
                begin
                    m_reg  <= '0;
                    c_reg  <= '0;
                    hm_reg <= '0;
                end
                else if (move_up)
                begin
                    m_reg <= up_bin;
                    c_reg <= c_hi[COUNT_BITS-1:0];
                end
                else if (move_down)
                begin
                    m_reg <= below_bin;
                    c_reg <= c_new;
                end
                else
                begin
                    c_reg  <= c_new;
                    hm_reg <= hm_new;
                end
            end
            else if (cmd.finish)
            begin
                hm_reg <= rd_reg;
                c_reg  <= c_mv;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign stat.move_needed = move_up || move_down;
    assign stat.out_busy    = out_valid_reg;

    a_below_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        c_reg <= n_reg)
        else $error("count below median exceeds held count");

    a_empty_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg == '0) |-> ((m_reg == '0) && (c_reg == '0)))
        else $error("empty histogram with nonzero median state");

    a_median_bin_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg != '0) |-> flags_reg[m_reg])
        else $error("median bin not occupied");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

/* rtl/running_median_histogram_top.sv */
// top level of the running median histogram block
// timing: out_valid rises from the update state when the median stays in its bin, or from the
//   move state when it steps to the neighboring occupied bin; loads wait for a free output
// sequencing: one item at a time, set by the read-modify-write of the bin memory plus one
//   read of the new median bin
// reset: counts, median state and per-bin occupancy flags cleared at once, no clearing pass
`default_nettype none

module running_median_histogram_top
    import rmh_pkg::*;
#(
    parameter int VALUE_LEVELS = 256,
    parameter int COUNT_BITS   = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    cmd_t  cmd;
    stat_t stat;

    rmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rmh_datapath #(
        .VALUE_LEVELS (VALUE_LEVELS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
